### rtl/rlsp_pkg.sv
// shared types and constants for the refund leaf script parser
// no dependencies; used by rlsp_parser and refund_leaf_script_parser_top
package rlsp_pkg;

    // script opcodes the parser looks for
    localparam logic [7:0] OP_PUSH32     = 8'h20;
    localparam logic [7:0] OP_VERIFY     = 8'hAD;
    localparam logic [7:0] OP_PUSH_MIN   = 8'h01;
    localparam logic [7:0] OP_PUSH_MAX   = 8'h4B;
    localparam logic [7:0] OP_PUSH_LEN1  = 8'h4C;
    localparam logic [7:0] OP_SMALL_MIN  = 8'h51;
    localparam logic [7:0] OP_SMALL_MAX  = 8'h60;
    localparam logic [7:0] OP_SMALL_BASE = 8'h50;
    localparam logic [7:0] OP_CSV        = 8'hB2;

    // number encoding
    localparam logic [7:0] SIGN_BIT    = 8'h80;
    localparam int         VALUE_BYTES = 4;
    localparam logic [30:0] TIMELOCK_MAX = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_KEY     = 2'd1,
        KIND_VERDICT = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ERR_OK     = 4'd0,
        ERR_FIRST  = 4'd1,
        ERR_VERIFY = 4'd2,
        ERR_PUSH   = 4'd3,
        ERR_NEG    = 4'd4,
        ERR_ZERO   = 4'd5,
        ERR_CSV    = 4'd6,
        ERR_TRAIL  = 4'd7,
        ERR_TRUNC  = 4'd8
    } error_code_t;

    typedef enum logic [7:0] {
        PH_FIRST  = 8'b0000_0001,
        PH_KEY    = 8'b0000_0010,
        PH_VERIFY = 8'b0000_0100,
        PH_PUSHOP = 8'b0000_1000,
        PH_PDLEN  = 8'b0001_0000,
        PH_DATA   = 8'b0010_0000,
        PH_CSV    = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] script_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  key_byte;
        logic [4:0]  key_index;
        logic        accepted;
        logic [30:0] timelock;
        error_code_t error_code;
    } out_beat_t;

endpackage

### rtl/rlsp_parser.sv
// parser state and next-state logic for the refund leaf script parser
// depends on rlsp_pkg; advances one script byte per step pulse
module rlsp_parser #(
    parameter int unsigned KEY_BYTES        = 32,
    parameter int unsigned MAX_NUMBER_BYTES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  rlsp_pkg::in_beat_t  beat,
    output rlsp_pkg::out_beat_t result
);

    localparam int unsigned CW = $clog2(MAX_NUMBER_BYTES + 1);
    localparam logic [4:0]  KEY_LAST = 5'(KEY_BYTES - 1);
    localparam logic [7:0]  MAX_LEN  = 8'(MAX_NUMBER_BYTES);

    rlsp_pkg::phase_t      phase_reg, phase_next, phase_upd;
    logic [4:0]            count_reg, count_next, count_upd;
    logic [CW-1:0]         rem_reg, rem_next, rem_upd, rem_dec;
    logic [CW-1:0]         total_reg, total_next, total_upd;
    logic [31:0]           acc_reg, acc_next, acc_upd, acc_data;
    rlsp_pkg::error_code_t err_reg, err_next, err_upd, err_verdict;
    logic [CW+2:0]         shamt;
    logic [7:0]            b;
    logic                  key_out;
    logic                  do_start;

    assign b     = beat.script_byte;
    assign shamt = {total_reg, 3'b000};

    // per-byte parse step
    always_comb
    begin
        phase_upd = phase_reg;
        count_upd = count_reg;
        rem_upd   = rem_reg;
        total_upd = total_reg;
        acc_upd   = acc_reg;
        err_upd   = err_reg;
        key_out   = 1'b0;
        do_start  = 1'b0;
        rem_dec   = rem_reg - CW'(1);
        acc_data  = acc_reg;

        if (err_reg == rlsp_pkg::ERR_OK)
        begin
            case (phase_reg)
                rlsp_pkg::PH_FIRST:
                begin
                    if (b != rlsp_pkg::OP_PUSH32)
                    begin
                        err_upd = rlsp_pkg::ERR_FIRST;
                    end
                    else
                    begin
                        count_upd = 5'd0;
                        phase_upd = rlsp_pkg::PH_KEY;
                    end
                end
                rlsp_pkg::PH_KEY:
                begin
                    key_out   = 1'b1;
                    count_upd = count_reg + 5'd1;
                    if (count_reg == KEY_LAST)
                    begin
                        phase_upd = rlsp_pkg::PH_VERIFY;
                    end
                end
                rlsp_pkg::PH_VERIFY:
                begin
                    if (b != rlsp_pkg::OP_VERIFY)
                    begin
                        err_upd = rlsp_pkg::ERR_VERIFY;
                    end
                    else
                    begin
                        phase_upd = rlsp_pkg::PH_PUSHOP;
                    end
                end
                rlsp_pkg::PH_PUSHOP:
                begin
                    if (b >= rlsp_pkg::OP_PUSH_MIN && b <= rlsp_pkg::OP_PUSH_MAX)
                    begin
                        do_start = 1'b1;
                    end
                    else if (b == rlsp_pkg::OP_PUSH_LEN1)
                    begin
                        phase_upd = rlsp_pkg::PH_PDLEN;
                    end
                    else if (b >= rlsp_pkg::OP_SMALL_MIN && b <= rlsp_pkg::OP_SMALL_MAX)
                    begin
                        acc_upd   = 32'(b - rlsp_pkg::OP_SMALL_BASE);
                        phase_upd = rlsp_pkg::PH_CSV;
                    end
                    else
                    begin
                        err_upd = rlsp_pkg::ERR_PUSH;
                    end
                end
                rlsp_pkg::PH_PDLEN:
                begin
                    do_start = 1'b1;
                end
                rlsp_pkg::PH_DATA:
                begin
                    // little-endian accumulate, saturate on high nonzero bytes
                    if (int'(total_reg) < rlsp_pkg::VALUE_BYTES)
                    begin
                        acc_data = acc_reg | (32'(b) << shamt);
                    end
                    else if (b != 8'd0)
                    begin
                        acc_data = 32'hFFFF_FFFF;
                    end
                    acc_upd   = acc_data;
                    total_upd = total_reg + CW'(1);
                    rem_upd   = rem_dec;
                    if (rem_dec == CW'(0))
                    begin
                        if ((b & rlsp_pkg::SIGN_BIT) != 8'd0)
                        begin
                            err_upd = rlsp_pkg::ERR_NEG;
                        end
                        else if (acc_data == 32'd0)
                        begin
                            err_upd = rlsp_pkg::ERR_ZERO;
                        end
                        else
                        begin
                            phase_upd = rlsp_pkg::PH_CSV;
                        end
                    end
                end
                rlsp_pkg::PH_CSV:
                begin
                    if (b != rlsp_pkg::OP_CSV)
                    begin
                        err_upd = rlsp_pkg::ERR_CSV;
                    end
                    else
                    begin
                        phase_upd = rlsp_pkg::PH_DONE;
                    end
                end
                default:
                begin
                    err_upd = rlsp_pkg::ERR_TRAIL;
                end
            endcase
        end

        // start of a data push, length taken from the current byte
        if (do_start)
        begin
            if (b > MAX_LEN)
            begin
                err_upd = rlsp_pkg::ERR_PUSH;
            end
            else if (b == 8'd0)
            begin
                err_upd = rlsp_pkg::ERR_ZERO;
            end
            else
            begin
                rem_upd   = CW'(b);
                total_upd = CW'(0);
                acc_upd   = 32'd0;
                phase_upd = rlsp_pkg::PH_DATA;
            end
        end
    end

    // verdict on the final byte, then back to the start state
    always_comb
    begin
        err_verdict = err_upd;
        if (err_upd == rlsp_pkg::ERR_OK && phase_upd != rlsp_pkg::PH_DONE)
        begin
            err_verdict = rlsp_pkg::ERR_TRUNC;
        end

        result = '0;
        if (beat.last_byte)
        begin
            result.kind       = rlsp_pkg::KIND_VERDICT;
            result.accepted   = (err_verdict == rlsp_pkg::ERR_OK);
            result.error_code = err_verdict;
            if (err_verdict == rlsp_pkg::ERR_OK)
            begin
                result.timelock = acc_upd[31] ? rlsp_pkg::TIMELOCK_MAX : acc_upd[30:0];
            end
            phase_next = rlsp_pkg::PH_FIRST;
            count_next = 5'd0;
            rem_next   = CW'(0);
            total_next = CW'(0);
            acc_next   = 32'd0;
            err_next   = rlsp_pkg::ERR_OK;
        end
        else
        begin
            if (key_out)
            begin
                result.kind      = rlsp_pkg::KIND_KEY;
                result.key_byte  = b;
                result.key_index = count_reg;
            end
            phase_next = phase_upd;
            count_next = count_upd;
            rem_next   = rem_upd;
            total_next = total_upd;
            acc_next   = acc_upd;
            err_next   = err_upd;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rlsp_pkg::PH_FIRST;
            count_reg <= 5'd0;
            rem_reg   <= CW'(0);
            total_reg <= CW'(0);
            acc_reg   <= 32'd0;
            err_reg   <= rlsp_pkg::ERR_OK;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            total_reg <= total_next;
            acc_reg   <= acc_next;
            err_reg   <= err_next;
        end
    end

endmodule

### rtl/refund_leaf_script_parser_top.sv
// top level of the refund leaf script parser: input and result registers
// depends on rlsp_pkg and rlsp_parser
//
// Takes one script byte per beat and returns exactly one result beat per
// input beat: nothing, a key byte with its index, or, on the beat flagged as
// last, the verdict with error code and decoded timelock. A new byte is taken
// every clock cycle unless script_stall is raised by a held result; each byte
// passes through the input register, the combinational parse step and the
// result register. The parser returns to its start state after each verdict.
module refund_leaf_script_parser_top #(
    parameter int unsigned KEY_BYTES        = 32,
    parameter int unsigned MAX_NUMBER_BYTES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                script_valid,
    output logic                script_stall,
    input  rlsp_pkg::in_beat_t  script,
    output logic                result_valid,
    input  logic                result_stall,
    output rlsp_pkg::out_beat_t result
);

    logic                in_valid_reg;
    rlsp_pkg::in_beat_t  in_reg;
    logic                out_valid_reg;
    rlsp_pkg::out_beat_t out_reg;
    rlsp_pkg::out_beat_t parse_result;
    logic                out_free;
    logic                advance;
    logic                accept;

    // handshake control
    assign out_free     = !out_valid_reg || !result_stall;
    assign advance      = in_valid_reg && out_free;
    assign script_stall = in_valid_reg && !out_free;
    assign accept       = script_valid && !script_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // parse step
    rlsp_parser #(
        .KEY_BYTES        (KEY_BYTES),
        .MAX_NUMBER_BYTES (MAX_NUMBER_BYTES)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .beat   (in_reg),
        .result (parse_result)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept || (in_valid_reg && !advance);
            if (out_free)
            begin
                out_valid_reg <= advance;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= script;
        end
        if (advance)
        begin
            out_reg <= parse_result;
        end
    end

    // checks
    a_verdict_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == rlsp_pkg::KIND_VERDICT) |->
            (out_reg.accepted == (out_reg.error_code == rlsp_pkg::ERR_OK)))
        else $error("verdict accepted flag disagrees with error code");

    a_accepted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.accepted) |-> (out_reg.timelock != 31'd0))
        else $error("accepted verdict with zero timelock");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && result_stall) |-> script_stall)
        else $error("input taken while both stages are held");

    a_non_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind != rlsp_pkg::KIND_VERDICT) |->
            (out_reg.error_code == rlsp_pkg::ERR_OK && !out_reg.accepted))
        else $error("error reported outside a verdict beat");

endmodule
